>>> rtl/core/mfr_pkg.sv
// Shared types and constants for the Manchester frame receiver.
`default_nettype none

package mfr_pkg;

    localparam logic [7:0]  MSG_BYTES       = 8'd64;
    localparam logic [4:0]  HALVES_PER_BYTE = 5'd20;
    localparam logic [15:0] IDLE_LIMIT_RST  = 16'd40;

    localparam int unsigned ERR_START = 0;
    localparam int unsigned ERR_LOW   = 1;
    localparam int unsigned ERR_HIGH  = 2;
    localparam int unsigned ERR_STOP  = 3;

    typedef enum logic [1:0] {
        MODE_BEGIN = 2'd0,
        MODE_START = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic       message_done;
        logic [7:0] message_length;
        logic [3:0] error_flags;
        logic       start_armed;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mfr_decode.sv
// Receiver state and the single-pass per-sample decode step.
`default_nettype none

module mfr_decode
    import mfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [1:0]  mode,
    input  wire logic        line_level,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    output result_t          res
);

    logic [4:0]  half_count_reg, half_count_next;
    logic        start_half_reg, start_half_next;
    logic        first_half_reg, first_half_next;
    logic        stop_half_reg, stop_half_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [3:0]  byte_errors_reg, byte_errors_next;
    logic [7:0]  msg_ptr_reg, msg_ptr_next;
    logic [15:0] idle_count_reg, idle_count_next;
    logic        prev_level_reg, prev_level_next;
    logic        armed_reg, armed_next;
    logic [15:0] idle_limit_reg;

    logic [4:0]  h;
    logic [4:0]  h_off;
    logic [2:0]  pos;
    logic [3:0]  errs;
    logic [7:0]  ptr;

    assign h     = half_count_reg;
    assign h_off = h - 5'd2;
    assign pos   = h_off[3:1];

    always_comb
    begin
        half_count_next  = half_count_reg;
        start_half_next  = start_half_reg;
        first_half_next  = first_half_reg;
        stop_half_next   = stop_half_reg;
        shift_byte_next  = shift_byte_reg;
        byte_errors_next = byte_errors_reg;
        msg_ptr_next     = msg_ptr_reg;
        idle_count_next  = idle_count_reg;
        prev_level_next  = prev_level_reg;
        armed_next       = armed_reg;
        errs             = byte_errors_reg;
        ptr              = msg_ptr_reg;
        res              = '0;

        case (mode)
            MODE_BEGIN:
            begin
                idle_count_next = '0;
                msg_ptr_next    = '0;
            end
            MODE_START:
            begin
                start_half_next  = line_level;
                half_count_next  = 5'd1;
                byte_errors_next = '0;
                armed_next       = 1'b0;
            end
            MODE_TICK:
            begin
                if (h < HALVES_PER_BYTE)
                begin
                    if (h == 5'd1)
                    begin
                        if (start_half_reg | line_level)
                        begin
                            errs            = '0;
                            errs[ERR_START] = 1'b1;
                        end
                    end
                    else if ((h inside {[5'd2:5'd17]}) && !h[0])
                    begin
                        first_half_next = line_level;
                    end
                    else if (h inside {[5'd3:5'd17]})
                    begin
                        if (!first_half_reg && !line_level)
                            errs[ERR_LOW] = 1'b1;
                        else if (first_half_reg && line_level)
                            errs[ERR_HIGH] = 1'b1;
                        shift_byte_next[pos] = !first_half_reg && line_level;
                    end
                    else if (h == 5'd18)
                    begin
                        stop_half_next = line_level;
                    end
                    else if (h == 5'd19)
                    begin
                        if (!(stop_half_reg & line_level))
                            errs[ERR_STOP] = 1'b1;
                        if (errs == 4'd0)
                        begin
                            if (msg_ptr_reg != 8'd0 && msg_ptr_reg < MSG_BYTES)
                            begin
                                res.byte_valid = 1'b1;
                                res.byte_value = shift_byte_reg;
                                res.byte_index = msg_ptr_reg - 8'd1;
                            end
                            shift_byte_next = '0;
                            if (msg_ptr_reg != 8'hFF)
                                ptr = msg_ptr_reg + 8'd1;
                        end
                        armed_next = 1'b1;
                    end
                    half_count_next = h + 5'd1;
                end

                if (line_level == prev_level_reg)
                begin
                    if (idle_count_reg != 16'hFFFF)
                        idle_count_next = idle_count_reg + 16'd1;
                end
                else
                begin
                    idle_count_next = '0;
                end
                prev_level_next = line_level;

                if (idle_count_next > idle_limit_reg)
                begin
                    half_count_next = '0;
                    if (errs != 4'd0)
                        ptr = '0;
                    armed_next = 1'b0;
                    res.message_done = 1'b1;
                    res.message_length = (ptr != 8'd0) ? ptr - 8'd1 : 8'd0;
                end
                byte_errors_next = errs;
                msg_ptr_next     = ptr;
            end
            default:
            begin
            end
        endcase

        res.error_flags = byte_errors_next;
        res.start_armed = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_count_reg  <= '0;
            start_half_reg  <= 1'b0;
            first_half_reg  <= 1'b0;
            stop_half_reg   <= 1'b0;
            shift_byte_reg  <= '0;
            byte_errors_reg <= '0;
            msg_ptr_reg     <= '0;
            idle_count_reg  <= '0;
            prev_level_reg  <= 1'b0;
            armed_reg       <= 1'b1;
        end
        else if (step)
        begin
            half_count_reg  <= half_count_next;
            start_half_reg  <= start_half_next;
            first_half_reg  <= first_half_next;
            stop_half_reg   <= stop_half_next;
            shift_byte_reg  <= shift_byte_next;
            byte_errors_reg <= byte_errors_next;
            msg_ptr_reg     <= msg_ptr_next;
            idle_count_reg  <= idle_count_next;
            prev_level_reg  <= prev_level_next;
            armed_reg       <= armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_limit_reg <= IDLE_LIMIT_RST;
        else if (cfg_we)
            idle_limit_reg <= cfg_data;
    end

    a_half_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        half_count_reg <= HALVES_PER_BYTE)
        else $error("half count out of range");

    a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.byte_valid) |=> msg_ptr_reg == $past(msg_ptr_reg) + 8'd1)
        else $error("pointer did not advance after an emitted byte");

    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.message_done) |=> (half_count_reg == 5'd0) && !armed_reg)
        else $error("timeout did not reset the byte framer");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode == MODE_START) |=>
            (half_count_reg == 5'd1) && (byte_errors_reg == 4'd0))
        else $error("start sample did not restart the byte");

endmodule

`default_nettype wire

>>> rtl/core/mfr_out_reg.sv
// Result register holding one finished item until the consumer takes it.
`default_nettype none

module mfr_out_reg
    import mfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res_in,
    input  wire logic    out_ready,
    output logic         out_valid,
    output result_t      res_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

`default_nettype wire

>>> rtl/core/manchester_frame_receiver.sv
// Top level of the Manchester frame receiver: input register, decode step, result register.
//
// Takes one line-sample item per clock as long as results are taken. The item
// is captured in an input register at acceptance; when it advances, it is
// decoded and applied to the receiver state in one pass, and its result is
// loaded into the output register at the same edge and held until taken.
// Throughput is one item per cycle as long as results are taken; a stalled
// result blocks only once both registers are full. idle_limit is written
// through the cfg port (reset 40); the user must write it only while the
// receiver is idle, which the block itself does not enforce.
`default_nettype none

module manchester_frame_receiver
    import mfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic        line_level,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             byte_valid,
    output logic [7:0]       byte_value,
    output logic [7:0]       byte_index,
    output logic             message_done,
    output logic [7:0]       message_length,
    output logic [3:0]       error_flags,
    output logic             start_armed,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_mode_reg;
    logic       s1_level_reg;
    logic       advance;
    logic       in_take;
    result_t    res_step;
    result_t    res_held;

    assign advance   = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg  <= mode;
            s1_level_reg <= line_level;
        end
    end

    mfr_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .mode       (s1_mode_reg),
        .line_level (s1_level_reg),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .res        (res_step)
    );

    mfr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_step),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_held)
    );

    assign byte_valid     = res_held.byte_valid;
    assign byte_value     = res_held.byte_value;
    assign byte_index     = res_held.byte_index;
    assign message_done   = res_held.message_done;
    assign message_length = res_held.message_length;
    assign error_flags    = res_held.error_flags;
    assign start_armed    = res_held.start_armed;

endmodule

`default_nettype wire
